/* rtl/core/sorted_key_index_table_top_macros.svh */
// Assertion macros used by the checker of the sorted key index table.
// No dependencies; included by the checker file.
`ifndef SORTED_KEY_INDEX_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_INDEX_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SKIT_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SKIT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/skit_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the
// sorted key index table. No dependencies.
package skit_pkg;

	localparam int DEPTH      = 64;
	localparam int KEY_BITS   = 16;
	localparam int ADDR_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int OP_BITS    = 2;
	localparam int ARG_BITS   = 16;
	localparam int POS_BITS   = 6;
	localparam int SLOT_BITS  = 6;
	localparam int TOTAL_BITS = 7;

	typedef enum logic [OP_BITS-1:0] {
		OP_SEARCH = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RS_ZERO,
		RS_HIT,
		RS_INSERT,
		RS_DELETE
	} res_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_BS_CHECK,
		S_KEY_RD,
		S_CMP,
		S_INS_SHIFT,
		S_INS_WRITE,
		S_DEL_SLOT,
		S_DEL_SWEEP,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic     latch_in;
		logic     bs_init;
		logic     idx_rd_mid;
		logic     key_rd_slot;
		logic     bs_step;
		logic     ins_shift;
		logic     ins_write;
		logic     del_rd_pos;
		logic     del_cap;
		logic     del_sweep;
		logic     count_dec;
		logic     set_res;
		status_t  res_status;
		res_sel_t res_sel;
		logic     emit;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic pos_bad;
		logic bs_open;
		logic key_eq;
		logic ins_done;
		logic del_done;
		logic out_free;
	} dp_stat_t;

endpackage

/* rtl/core/skit_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skit_ram #(
	parameter int WIDTH = 8,
	parameter int WORDS = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(WORDS)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(WORDS)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [WORDS];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

/* rtl/core/skit_ctrl.sv */
// Controller state machine of the sorted key index table.
// Depends on skit_pkg; drives skit_dp through ctrl_cmd_t.
module skit_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  skit_pkg::dp_stat_t   stat,
	output skit_pkg::ctrl_cmd_t  cmd
);

	import skit_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (stat.op)
					OP_SEARCH: state_d = S_BS_CHECK;
					OP_INSERT: state_d = stat.full ? S_FINISH : S_BS_CHECK;
					OP_DELETE: state_d = stat.pos_bad ? S_FINISH : S_DEL_SLOT;
					default:   state_d = S_FINISH;
				endcase
			end
			S_BS_CHECK: begin
				if (stat.bs_open) state_d = S_KEY_RD;
				else if (stat.op == OP_INSERT) state_d = S_INS_SHIFT;
				else state_d = S_FINISH;
			end
			S_KEY_RD: state_d = S_CMP;
			S_CMP: begin
				if (stat.op == OP_SEARCH && stat.key_eq) state_d = S_FINISH;
				else state_d = S_BS_CHECK;
			end
			S_INS_SHIFT: begin
				if (stat.ins_done) state_d = S_INS_WRITE;
			end
			S_INS_WRITE: state_d = S_FINISH;
			S_DEL_SLOT:  state_d = S_DEL_SWEEP;
			S_DEL_SWEEP: begin
				if (stat.del_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
			end
			S_DISPATCH: begin
				case (stat.op)
					OP_SEARCH: cmd.bs_init = 1'b1;
					OP_INSERT: begin
						if (stat.full) begin
							cmd.set_res    = 1'b1;
							cmd.res_status = ST_FULL;
							cmd.res_sel    = RS_ZERO;
						end else begin
							cmd.bs_init = 1'b1;
						end
					end
					OP_DELETE: begin
						if (stat.pos_bad) begin
							cmd.set_res    = 1'b1;
							cmd.res_status = ST_RANGE;
							cmd.res_sel    = RS_ZERO;
						end else begin
							cmd.del_rd_pos = 1'b1;
						end
					end
					default: begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_OK;
						cmd.res_sel    = RS_ZERO;
					end
				endcase
			end
			S_BS_CHECK: begin
				if (stat.bs_open) begin
					cmd.idx_rd_mid = 1'b1;
				end else if (stat.op != OP_INSERT) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					cmd.res_sel    = RS_ZERO;
				end
			end
			S_KEY_RD: cmd.key_rd_slot = 1'b1;
			S_CMP: begin
				if (stat.op == OP_SEARCH && stat.key_eq) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_sel    = RS_HIT;
				end else begin
					cmd.bs_step = 1'b1;
				end
			end
			S_INS_SHIFT: cmd.ins_shift = 1'b1;
			S_INS_WRITE: begin
				cmd.ins_write  = 1'b1;
				cmd.set_res    = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_sel    = RS_INSERT;
			end
			S_DEL_SLOT: cmd.del_cap = 1'b1;
			S_DEL_SWEEP: begin
				cmd.del_sweep = 1'b1;
				if (stat.del_done) begin
					cmd.count_dec  = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_sel    = RS_DELETE;
				end
			end
			S_FINISH: cmd.emit = stat.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/core/skit_dp.sv */
// Datapath of the sorted key index table: key and order RAMs, search
// bounds, sweep pointer and result register. Depends on skit_pkg, skit_ram.
module skit_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  skit_pkg::ctrl_cmd_t            cmd,
	output skit_pkg::dp_stat_t             stat,
	input  logic [skit_pkg::OP_BITS-1:0]   operation,
	input  logic [skit_pkg::ARG_BITS-1:0]  argument,
	output logic                           out_valid,
	input  logic                           out_ready,
	output skit_pkg::status_t              status,
	output logic [skit_pkg::POS_BITS-1:0]  position,
	output logic [skit_pkg::SLOT_BITS-1:0] slot,
	output logic [skit_pkg::TOTAL_BITS-1:0] entry_total
);

	import skit_pkg::*;

	logic [OP_BITS-1:0]    op_q;
	logic [ARG_BITS-1:0]   arg_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   lo_q;
	logic [CNT_BITS-1:0]   hi_q;
	logic [CNT_BITS-1:0]   i_q;
	logic [ADDR_BITS-1:0]  mid_q;
	logic [ADDR_BITS-1:0]  slot_q;
	logic                  pend_q;
	logic [ADDR_BITS-1:0]  pend_addr_q;
	logic                  pend_del_q;
	logic                  pend_key_q;
	status_t               res_status_q;
	res_sel_t              res_sel_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [POS_BITS-1:0]   out_pos_q;
	logic [SLOT_BITS-1:0]  out_slot_q;
	logic [TOTAL_BITS-1:0] out_total_q;

	logic [KEY_BITS-1:0]   key_w;
	logic [CNT_BITS:0]     mid_sum;
	logic [ADDR_BITS-1:0]  mid_w;
	logic [CNT_BITS-1:0]   i_inc;
	logic [CNT_BITS-1:0]   i_dec;
	logic [CNT_BITS-1:0]   cnt_dec;
	logic                  ins_read;
	logic                  del_read;
	logic                  out_free;

	logic                  idx_wr_en;
	logic [ADDR_BITS-1:0]  idx_wr_addr;
	logic [ADDR_BITS-1:0]  idx_wr_data;
	logic                  idx_rd_en;
	logic [ADDR_BITS-1:0]  idx_rd_addr;
	logic [ADDR_BITS-1:0]  idx_rd;
	logic [ADDR_BITS-1:0]  idx_adj;
	logic                  key_wr_en;
	logic [ADDR_BITS-1:0]  key_wr_addr;
	logic [KEY_BITS-1:0]   key_wr_data;
	logic                  key_rd_en;
	logic [ADDR_BITS-1:0]  key_rd_addr;
	logic [KEY_BITS-1:0]   key_rd;

	assign key_w   = KEY_BITS'(arg_q);
	assign mid_sum = (CNT_BITS+1)'(lo_q) + (CNT_BITS+1)'(hi_q) - (CNT_BITS+1)'(1);
	assign mid_w   = mid_sum[ADDR_BITS:1];
	assign i_inc   = i_q + CNT_BITS'(1);
	assign i_dec   = i_q - CNT_BITS'(1);
	assign cnt_dec = count_q - CNT_BITS'(1);
	assign idx_adj = (idx_rd > slot_q) ? idx_rd - ADDR_BITS'(1) : idx_rd;
	assign out_free = !out_valid_q || out_ready;

	assign stat.op       = op_t'(op_q);
	assign stat.full     = (count_q == CNT_BITS'(DEPTH));
	assign stat.pos_bad  = (arg_q >= ARG_BITS'(count_q));
	assign stat.bs_open  = (lo_q < hi_q);
	assign stat.key_eq   = (key_rd == key_w);
	assign stat.ins_done = (i_q == lo_q);
	assign stat.del_done = (i_q == cnt_dec);
	assign stat.out_free = out_free;

	assign ins_read = cmd.ins_shift && !stat.ins_done;
	assign del_read = cmd.del_sweep && !stat.del_done;

	always_comb begin
		idx_rd_en   = 1'b1;
		idx_rd_addr = mid_w;
		if (cmd.idx_rd_mid) begin
			idx_rd_addr = mid_w;
		end else if (ins_read) begin
			idx_rd_addr = ADDR_BITS'(i_dec);
		end else if (cmd.del_rd_pos) begin
			idx_rd_addr = ADDR_BITS'(arg_q);
		end else if (del_read) begin
			idx_rd_addr = (ARG_BITS'(i_q) < arg_q) ? ADDR_BITS'(i_q) : ADDR_BITS'(i_inc);
		end else begin
			idx_rd_en = 1'b0;
		end
	end

	always_comb begin
		idx_wr_en   = 1'b0;
		idx_wr_addr = pend_addr_q;
		idx_wr_data = idx_rd;
		if (pend_q) begin
			idx_wr_en   = 1'b1;
			idx_wr_data = pend_del_q ? idx_adj : idx_rd;
		end else if (cmd.ins_write) begin
			idx_wr_en   = 1'b1;
			idx_wr_addr = ADDR_BITS'(lo_q);
			idx_wr_data = ADDR_BITS'(count_q);
		end
	end

	assign key_rd_en   = cmd.key_rd_slot || del_read;
	assign key_rd_addr = cmd.key_rd_slot ? idx_rd : ADDR_BITS'(i_inc);
	assign key_wr_en   = (pend_q && pend_key_q) || cmd.ins_write;
	assign key_wr_addr = cmd.ins_write ? ADDR_BITS'(count_q) : pend_addr_q;
	assign key_wr_data = cmd.ins_write ? key_w : key_rd;

	skit_ram #(
		.WIDTH (ADDR_BITS),
		.WORDS (DEPTH)
	) u_idx_ram (
		.clk     (clk),
		.wr_en   (idx_wr_en),
		.wr_addr (idx_wr_addr),
		.wr_data (idx_wr_data),
		.rd_en   (idx_rd_en),
		.rd_addr (idx_rd_addr),
		.rd_data (idx_rd)
	);

	skit_ram #(
		.WIDTH (KEY_BITS),
		.WORDS (DEPTH)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_wr_en),
		.wr_addr (key_wr_addr),
		.wr_data (key_wr_data),
		.rd_en   (key_rd_en),
		.rd_addr (key_rd_addr),
		.rd_data (key_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_write) count_q <= count_q + CNT_BITS'(1);
			else if (cmd.count_dec) count_q <= cnt_dec;
			pend_q <= ins_read || del_read;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q  <= operation;
			arg_q <= argument;
		end
		if (cmd.bs_init) begin
			lo_q <= '0;
			hi_q <= count_q;
			i_q  <= count_q;
		end else if (cmd.bs_step) begin
			if (key_rd < key_w) lo_q <= CNT_BITS'(mid_q) + CNT_BITS'(1);
			else hi_q <= CNT_BITS'(mid_q);
		end
		if (cmd.del_cap) i_q <= '0;
		else if (ins_read) i_q <= i_dec;
		else if (del_read) i_q <= i_inc;
		if (cmd.idx_rd_mid) mid_q <= mid_w;
		if (cmd.key_rd_slot || cmd.del_cap) slot_q <= idx_rd;
		else if (cmd.ins_write) slot_q <= ADDR_BITS'(count_q);
		pend_addr_q <= ADDR_BITS'(i_q);
		pend_del_q  <= del_read;
		pend_key_q  <= del_read && (i_q >= CNT_BITS'(slot_q));
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_sel_q    <= cmd.res_sel;
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_total_q  <= TOTAL_BITS'(count_q);
			case (res_sel_q)
				RS_HIT: begin
					out_pos_q  <= POS_BITS'(mid_q);
					out_slot_q <= SLOT_BITS'(slot_q);
				end
				RS_INSERT: begin
					out_pos_q  <= POS_BITS'(lo_q);
					out_slot_q <= SLOT_BITS'(slot_q);
				end
				RS_DELETE: begin
					out_pos_q  <= POS_BITS'(arg_q);
					out_slot_q <= SLOT_BITS'(slot_q);
				end
				default: begin
					out_pos_q  <= '0;
					out_slot_q <= '0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign position    = out_pos_q;
	assign slot        = out_slot_q;
	assign entry_total = out_total_q;

endmodule

/* rtl/core/sorted_key_index_table_top.sv */
// Sorted key index table, top level. One item in flight; result held in an output register.
// Search and insert take up to ceil(log2(n+1)) binary search steps over n entries; insert then
// shifts the entries above its position and delete sweeps the table. Full, bad position or unused
// code end without a search. An untaken result holds the next item in its last state.
// Reset clears the entry count, state machine and output valid; RAM contents are not cleared.
// Depends on skit_pkg, skit_ctrl, skit_dp.
module sorted_key_index_table_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [skit_pkg::OP_BITS-1:0]    operation,
	input  logic [skit_pkg::ARG_BITS-1:0]   argument,
	output logic                            out_valid,
	input  logic                            out_ready,
	output skit_pkg::status_t               status,
	output logic [skit_pkg::POS_BITS-1:0]   position,
	output logic [skit_pkg::SLOT_BITS-1:0]  slot,
	output logic [skit_pkg::TOTAL_BITS-1:0] entry_total
);

	import skit_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	skit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	skit_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (operation),
		.argument    (argument),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.position    (position),
		.slot        (slot),
		.entry_total (entry_total)
	);

endmodule

/* rtl/core/skit_checker.sv */
// Port-level checker of the sorted key index table and its bind to the top level.
// Depends on skit_pkg and sorted_key_index_table_top_macros.svh.
`include "sorted_key_index_table_top_macros.svh"

module skit_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input skit_pkg::status_t               status,
	input logic [skit_pkg::POS_BITS-1:0]   position,
	input logic [skit_pkg::SLOT_BITS-1:0]  slot,
	input logic [skit_pkg::TOTAL_BITS-1:0] entry_total
);

	import skit_pkg::*;

	`SKIT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(position) && $stable(slot) && $stable(entry_total), "output beat changed while stalled")
	`SKIT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while an item is in flight")
	`SKIT_ASSERT_NOW(a_err_fields_zero, clk, arst_n, out_valid && status != ST_OK, position == '0 && slot == '0, "error beat with nonzero position or slot")
	`SKIT_ASSERT_NOW(a_full_total, clk, arst_n, out_valid && status == ST_FULL, entry_total == TOTAL_BITS'(DEPTH), "table full reported below capacity")

endmodule

bind sorted_key_index_table_top skit_checker u_checker (.*);
